// ===== src/hit_pkg.sv =====
// ----------------------------------------------------------------------------
// hit_pkg: shared types and constants of the homography inlier test
// Register indexes, reset values, stream packing and the sign flags of the
// projective denominator.
// ----------------------------------------------------------------------------
package hit_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] HIT_REG_H00_H01 = 3'd0;
	localparam logic [2:0] HIT_REG_H02_H10 = 3'd1;
	localparam logic [2:0] HIT_REG_H11_H12 = 3'd2;
	localparam logic [2:0] HIT_REG_H20_H21 = 3'd3;
	localparam logic [2:0] HIT_REG_TOL_SQ  = 3'd4;

	localparam int HIT_IDX_BITS  = 3;
	localparam int HIT_CFG_BITS  = 64;
	localparam int HIT_HALF_BITS = 32;
	localparam int HIT_TOL_BITS  = 32;

	// register reset values: identity homography, tolerance 9.0 px^2
	localparam logic [63:0] HIT_RST_H00_H01 = 64'h0001_0000_0000_0000;
	localparam logic [63:0] HIT_RST_H02_H10 = 64'h0;
	localparam logic [63:0] HIT_RST_H11_H12 = 64'h0001_0000_0000_0000;
	localparam logic [63:0] HIT_RST_H20_H21 = 64'h0;
	localparam logic [31:0] HIT_RST_TOL_SQ  = 32'd2304;

	// h22 = 1.0 in Q15.16 times the Q12.4 scale of the homogeneous one
	localparam int HIT_ONE_TERM = 1 << 20;

	// limb width of the wide multipliers
	localparam int HIT_LIMB_BITS = 32;

	// stream packing
	localparam int HIT_FIELD_BITS   = 16;
	localparam int HIT_IN_BITS      = 80;
	localparam int HIT_OUT_BITS     = 24;
	localparam int HIT_IN_X_LSB     = 16;
	localparam int HIT_IN_Y_LSB     = 32;
	localparam int HIT_IN_QX_LSB    = 48;
	localparam int HIT_IN_QY_LSB    = 64;
	localparam int HIT_OUT_INL_BIT  = 16;
	localparam int HIT_OUT_PAD_BITS = 7;

	typedef struct packed {
		logic neg;
		logic zero;
	} hit_dflag_t;

endpackage

// ===== src/hit_dly.sv =====
// ----------------------------------------------------------------------------
// hit_dly: stage-aligned delay line
// Carries a value down the pipeline, each tap loading with its stage enable.
// ----------------------------------------------------------------------------
module hit_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic [N-1:0] en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [N];

	for (genvar k = 0; k < N; k++) begin : g_tap
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k]) tap_s[k] <= d;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k]) tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign q = tap_s[N-1];

endmodule

// ===== src/hit_wmul.sv =====
// ----------------------------------------------------------------------------
// hit_wmul: pipelined wide unsigned multiplier
// Registers the operands, forms one 32x32 limb product per stage and folds
// the products into an accumulator one stage behind; spare stages pass.
// ----------------------------------------------------------------------------
module hit_wmul #(
	parameter int WA  = 32,
	parameter int WB  = 32,
	parameter int LAT = 4
) (
	input  logic             clk,
	input  logic [LAT-1:0]   en,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic [WA+WB-1:0] p
);

	localparam int LB = hit_pkg::HIT_LIMB_BITS;
	localparam int NA = (WA + LB - 1) / LB;
	localparam int NB = (WB + LB - 1) / LB;
	localparam int NP = NA * NB;
	localparam int WR = WA + WB;

	logic [NA*LB-1:0] a_s   [NP];
	logic [NB*LB-1:0] b_s   [NP];
	logic [2*LB-1:0]  pp_s  [NP];
	logic [WR-1:0]    term  [NP];
	logic [WR-1:0]    acc_s [LAT-2];

	for (genvar k = 0; k < NP; k++) begin : g_pp
		localparam int I  = k / NB;
		localparam int J  = k % NB;
		localparam int SH = LB * (I + J);

		logic [WR+2*LB-1:0] ext;

		// carry the operands to the stage that forms limb product k
		if (k == 0) begin : g_op0
			always_ff @(posedge clk) begin
				if (en[k]) begin
					a_s[k] <= (NA*LB)'(a);
					b_s[k] <= (NB*LB)'(b);
				end
			end
		end else begin : g_opn
			always_ff @(posedge clk) begin
				if (en[k]) begin
					a_s[k] <= a_s[k-1];
					b_s[k] <= b_s[k-1];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k+1]) pp_s[k] <= a_s[k][I*LB +: LB] * b_s[k][J*LB +: LB];
		end

		assign ext     = (WR+2*LB)'(pp_s[k]) << SH;
		assign term[k] = ext[WR-1:0];
	end

	for (genvar k = 0; k < LAT - 2; k++) begin : g_acc
		if (k == 0) begin : g_acc0
			always_ff @(posedge clk) begin
				if (en[k+2]) acc_s[k] <= term[k];
			end
		end else if (k < NP) begin : g_add
			always_ff @(posedge clk) begin
				if (en[k+2]) acc_s[k] <= acc_s[k-1] + term[k];
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en[k+2]) acc_s[k] <= acc_s[k-1];
			end
		end
	end

	assign p = acc_s[LAT-3];

endmodule

// ===== src/hit_proj.sv =====
// ----------------------------------------------------------------------------
// hit_proj: projection front end
// Multiplies the source point by the homography rows, sums the terms and
// splits the denominator into magnitude and sign flags.
// ----------------------------------------------------------------------------
module hit_proj #(
	parameter int CB = 16,
	parameter int KB = 32
) (
	input  logic                        clk,
	input  logic [2:0]                  en,
	input  logic [CB-1:0]               x,
	input  logic [CB-1:0]               y,
	input  logic signed [KB-1:0]        h00,
	input  logic signed [KB-1:0]        h01,
	input  logic signed [KB-1:0]        h02,
	input  logic signed [KB-1:0]        h10,
	input  logic signed [KB-1:0]        h11,
	input  logic signed [KB-1:0]        h12,
	input  logic signed [KB-1:0]        h20,
	input  logic signed [KB-1:0]        h21,
	output logic signed [KB+CB+6:0]     nx16,
	output logic signed [KB+CB+6:0]     ny16,
	output logic [KB+CB+2:0]            dmag,
	output hit_pkg::hit_dflag_t         dflag
);

	localparam int PW = KB + CB + 1;
	localparam int NW = KB + CB + 3;
	localparam int XW = NW + 4;

	logic signed [PW-1:0] p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;
	logic signed [NW-1:0] nx_s2, ny_s2, den_s2;
	logic signed [XW-1:0] nx16_s3, ny16_s3;
	logic [NW-1:0]        dmag_s3;
	hit_pkg::hit_dflag_t  dflag_s3;
	logic signed [CB:0]   xs, ys;

	assign xs = $signed({1'b0, x});
	assign ys = $signed({1'b0, y});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p00_s1 <= xs * h00;
			p01_s1 <= ys * h01;
			p10_s1 <= xs * h10;
			p11_s1 <= ys * h11;
			p20_s1 <= xs * h20;
			p21_s1 <= ys * h21;
		end
	end

	// translation terms scale by 16 to match the Q12.4 coordinates
	always_ff @(posedge clk) begin
		if (en[1]) begin
			nx_s2  <= NW'(p00_s1) + NW'(p01_s1) + (NW'(h02) <<< 4);
			ny_s2  <= NW'(p10_s1) + NW'(p11_s1) + (NW'(h12) <<< 4);
			den_s2 <= NW'(p20_s1) + NW'(p21_s1) + NW'(hit_pkg::HIT_ONE_TERM);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			nx16_s3       <= XW'(nx_s2) <<< 4;
			ny16_s3       <= XW'(ny_s2) <<< 4;
			dmag_s3       <= den_s2[NW-1] ? $unsigned(-den_s2) : $unsigned(den_s2);
			dflag_s3.neg  <= den_s2[NW-1];
			dflag_s3.zero <= (den_s2 == '0);
		end
	end

	assign nx16  = nx16_s3;
	assign ny16  = ny16_s3;
	assign dmag  = dmag_s3;
	assign dflag = dflag_s3;

endmodule

// ===== src/homography_inlier_test_unit.sv =====
// ----------------------------------------------------------------------------
// homography_inlier_test_unit: division-free homography inlier test
// Pipeline depth grows with NBD, NE and NT, the 32-bit limb counts of the
//   denominator, the error terms and tol*|den|.
// Throughput: one transaction per cycle while m_tready does not stall the
//   output; every stage is a register, and the longer of the error-square
//   and tol*den^2 multipliers, one limb product per stage, sets their depth.
// Reset: arst_n clears all valid bits and loads the identity homography
//   with a 9.0 px^2 tolerance; data registers are not reset.
// ----------------------------------------------------------------------------
module homography_inlier_test_unit #(
	parameter int COORD_BITS = 16,
	parameter int COEF_BITS  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [hit_pkg::HIT_IDX_BITS-1:0]     cfg_index,
	input  logic [hit_pkg::HIT_CFG_BITS-1:0]     cfg_data,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata from bit 0: point_index, src_x, src_y, dst_x, dst_y
	input  logic [hit_pkg::HIT_IN_BITS-1:0]      s_tdata,
	input  logic                                 s_tlast,
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata from bit 0: result_index, is_inlier, zero fill
	output logic [hit_pkg::HIT_OUT_BITS-1:0]     m_tdata,
	output logic                                 m_tlast
);

	localparam int CB  = COORD_BITS;
	localparam int KB  = COEF_BITS;
	localparam int LB  = hit_pkg::HIT_LIMB_BITS;
	localparam int TW  = hit_pkg::HIT_TOL_BITS;
	localparam int FB  = hit_pkg::HIT_FIELD_BITS;
	// datapath widths
	localparam int NW  = KB + CB + 3;              // numerators and denominator
	localparam int XW  = NW + 4;                   // numerators scaled by 16
	localparam int MW  = NW;                       // |den|
	localparam int QW  = CB + MW;                  // q * |den|
	localparam int EW  = ((XW > QW + 1) ? XW : QW + 1) + 1;
	localparam int TDW = TW + MW;                  // tol * |den|
	localparam int SQW = 2 * EW;
	localparam int LW  = SQW + 1;                  // ex^2 + ey^2
	localparam int RW  = TDW + MW;                 // tol * den^2
	localparam int CW  = (LW > RW) ? LW : RW;
	// multiplier depths
	localparam int NBD = (MW + LB - 1) / LB;
	localparam int NE  = (EW + LB - 1) / LB;
	localparam int NT  = (TDW + LB - 1) / LB;
	localparam int LM1 = NBD + 2;
	localparam int LM2 = ((NE * NE > NT * NBD) ? NE * NE : NT * NBD) + 2;
	// stage map: projection, q/tol products, errors, squares, compare
	localparam int SB  = 3;
	localparam int SM1 = SB + LM1;
	localparam int SE1 = SM1 + 1;
	localparam int SE2 = SE1 + 1;
	localparam int SM2 = SE2 + LM2;
	localparam int SC1 = SM2 + 1;
	localparam int NS  = SC1 + 1;

	// ------------------------------------------------------------------
	// Configuration registers, unguarded: write only while pipeline is empty
	// ------------------------------------------------------------------
	logic [hit_pkg::HIT_CFG_BITS-1:0] coef0_q, coef1_q, coef2_q, coef3_q;
	logic [TW-1:0]                    tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef0_q <= hit_pkg::HIT_RST_H00_H01;
			coef1_q <= hit_pkg::HIT_RST_H02_H10;
			coef2_q <= hit_pkg::HIT_RST_H11_H12;
			coef3_q <= hit_pkg::HIT_RST_H20_H21;
			tol_q   <= hit_pkg::HIT_RST_TOL_SQ;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hit_pkg::HIT_REG_H00_H01: coef0_q <= cfg_data;
				hit_pkg::HIT_REG_H02_H10: coef1_q <= cfg_data;
				hit_pkg::HIT_REG_H11_H12: coef2_q <= cfg_data;
				hit_pkg::HIT_REG_H20_H21: coef3_q <= cfg_data;
				hit_pkg::HIT_REG_TOL_SQ:  tol_q   <= cfg_data[TW-1:0];
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// each coefficient is the low COEF_BITS of its half, read as signed
	localparam int HB = hit_pkg::HIT_HALF_BITS;
	logic signed [KB-1:0] h00, h01, h02, h10, h11, h12, h20, h21;

	assign h00 = $signed(coef0_q[HB +: KB]);
	assign h01 = $signed(coef0_q[0 +: KB]);
	assign h02 = $signed(coef1_q[HB +: KB]);
	assign h10 = $signed(coef1_q[0 +: KB]);
	assign h11 = $signed(coef2_q[HB +: KB]);
	assign h12 = $signed(coef2_q[0 +: KB]);
	assign h20 = $signed(coef3_q[HB +: KB]);
	assign h21 = $signed(coef3_q[0 +: KB]);

	// ------------------------------------------------------------------
	// Stage control: a stage advances when it is empty or its successor
	// advances, so bubbles collapse and the input keeps flowing while a
	// result waits at the output register, until the empty stages fill.
	// ------------------------------------------------------------------
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	assign en[NS-1] = !vld_q[NS-1] || m_tready;
	for (genvar k = 0; k < NS - 1; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= s_tvalid;
			for (int k = 1; k < NS; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NS-1];

	// coordinates: the low COORD_BITS of each 16-bit field
	logic [CB-1:0] src_x, src_y, dst_x, dst_y;

	assign src_x = CB'(s_tdata[hit_pkg::HIT_IN_X_LSB +: FB]);
	assign src_y = CB'(s_tdata[hit_pkg::HIT_IN_Y_LSB +: FB]);
	assign dst_x = CB'(s_tdata[hit_pkg::HIT_IN_QX_LSB +: FB]);
	assign dst_y = CB'(s_tdata[hit_pkg::HIT_IN_QY_LSB +: FB]);

	// ------------------------------------------------------------------
	// Projection: numerators and denominator of the transferred point
	// ------------------------------------------------------------------
	logic signed [XW-1:0] nx16, ny16;
	logic [MW-1:0]        dmag;
	hit_pkg::hit_dflag_t  dflag;

	hit_proj #(
		.CB (CB),
		.KB (KB)
	) u_proj (
		.clk   (clk),
		.en    (en[SB-1:0]),
		.x     (src_x),
		.y     (src_y),
		.h00   (h00),
		.h01   (h01),
		.h02   (h02),
		.h10   (h10),
		.h11   (h11),
		.h12   (h12),
		.h20   (h20),
		.h21   (h21),
		.nx16  (nx16),
		.ny16  (ny16),
		.dmag  (dmag),
		.dflag (dflag)
	);

	// hold the matched point until the denominator is ready
	logic [2*CB-1:0] qxy_d;

	hit_dly #(
		.W (2*CB),
		.N (SB)
	) u_dly_q (
		.clk (clk),
		.en  (en[SB-1:0]),
		.d   ({dst_y, dst_x}),
		.q   (qxy_d)
	);

	// ------------------------------------------------------------------
	// q * |den| and tol * |den|, all on the same schedule
	// ------------------------------------------------------------------
	logic [QW-1:0]  qxd, qyd;
	logic [TDW-1:0] tdm;

	hit_wmul #(.WA(CB), .WB(MW), .LAT(LM1)) u_mul_qx (
		.clk (clk), .en (en[SM1-1:SB]), .a (qxy_d[CB-1:0]), .b (dmag), .p (qxd)
	);

	hit_wmul #(.WA(CB), .WB(MW), .LAT(LM1)) u_mul_qy (
		.clk (clk), .en (en[SM1-1:SB]), .a (qxy_d[2*CB-1:CB]), .b (dmag), .p (qyd)
	);

	hit_wmul #(.WA(TW), .WB(MW), .LAT(LM1)) u_mul_td (
		.clk (clk), .en (en[SM1-1:SB]), .a (tol_q), .b (dmag), .p (tdm)
	);

	// numerators and sign ride alongside the products
	logic signed [XW-1:0] nx16_d, ny16_d;
	logic                 dneg_d;

	hit_dly #(
		.W (2*XW + 1),
		.N (LM1)
	) u_dly_num (
		.clk (clk),
		.en  (en[SM1-1:SB]),
		.d   ({dflag.neg, ny16, nx16}),
		.q   ({dneg_d, ny16_d, nx16_d})
	);

	// ------------------------------------------------------------------
	// Transfer errors: ex = 16*nx - qx*den, then magnitudes
	// ------------------------------------------------------------------
	logic signed [EW-1:0] nxe, nye, pxe, pye;
	logic signed [EW-1:0] ex_se1, ey_se1;
	logic [TDW-1:0]       td_se1, td_se2;
	logic [EW-1:0]        ax_se2, ay_se2;

	assign nxe = EW'(nx16_d);
	assign nye = EW'(ny16_d);
	assign pxe = $signed(EW'(qxd));
	assign pye = $signed(EW'(qyd));

	// a negative denominator flips the sign of the q*den term
	always_ff @(posedge clk) begin
		if (en[SE1-1]) begin
			ex_se1 <= dneg_d ? (nxe + pxe) : (nxe - pxe);
			ey_se1 <= dneg_d ? (nye + pye) : (nye - pye);
			td_se1 <= tdm;
		end
	end

	always_ff @(posedge clk) begin
		if (en[SE2-1]) begin
			ax_se2 <= ex_se1[EW-1] ? $unsigned(-ex_se1) : $unsigned(ex_se1);
			ay_se2 <= ey_se1[EW-1] ? $unsigned(-ey_se1) : $unsigned(ey_se1);
			td_se2 <= td_se1;
		end
	end

	logic [MW-1:0] dmag_d;

	hit_dly #(
		.W (MW),
		.N (SE2 - SB)
	) u_dly_dmag (
		.clk (clk),
		.en  (en[SE2-1:SB]),
		.d   (dmag),
		.q   (dmag_d)
	);

	// ------------------------------------------------------------------
	// Squares and tol * den^2, padded to one common depth
	// ------------------------------------------------------------------
	logic [SQW-1:0] sqx, sqy;
	logic [RW-1:0]  rhs;

	hit_wmul #(.WA(EW), .WB(EW), .LAT(LM2)) u_mul_sqx (
		.clk (clk), .en (en[SM2-1:SE2]), .a (ax_se2), .b (ax_se2), .p (sqx)
	);

	hit_wmul #(.WA(EW), .WB(EW), .LAT(LM2)) u_mul_sqy (
		.clk (clk), .en (en[SM2-1:SE2]), .a (ay_se2), .b (ay_se2), .p (sqy)
	);

	hit_wmul #(.WA(TDW), .WB(MW), .LAT(LM2)) u_mul_rhs (
		.clk (clk), .en (en[SM2-1:SE2]), .a (td_se2), .b (dmag_d), .p (rhs)
	);

	// zero denominator flag travels to the compare stage
	logic dzero_d;

	hit_dly #(
		.W (1),
		.N (SC1 - SB)
	) u_dly_zero (
		.clk (clk),
		.en  (en[SC1-1:SB]),
		.d   (dflag.zero),
		.q   (dzero_d)
	);

	// ------------------------------------------------------------------
	// Compare: ex^2 + ey^2 <= tol * den^2, zero denominator is an outlier
	// ------------------------------------------------------------------
	logic [LW-1:0] lhs_sc1;
	logic [RW-1:0] rhs_sc1;
	logic          inlier_sc2;

	always_ff @(posedge clk) begin
		if (en[SC1-1]) begin
			lhs_sc1 <= LW'(sqx) + LW'(sqy);
			rhs_sc1 <= rhs;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) inlier_sc2 <= !dzero_d && (CW'(lhs_sc1) <= CW'(rhs_sc1));
	end

	// index and last marker pass through the whole pipeline
	logic [FB-1:0] index_d;
	logic          last_d;

	hit_dly #(
		.W (FB + 1),
		.N (NS)
	) u_dly_side (
		.clk (clk),
		.en  (en),
		.d   ({s_tlast, s_tdata[FB-1:0]}),
		.q   ({last_d, index_d})
	);

	assign m_tdata = {{hit_pkg::HIT_OUT_PAD_BITS{1'b0}}, inlier_sc2, index_d};
	assign m_tlast = last_d;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// a free output side lets the input take a transaction
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled while output side is free");

	// an accepted transaction occupies the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted transaction lost at pipeline entry");

	// a zero denominator never yields an inlier
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(en[NS-1] && vld_q[NS-2] && dzero_d) |=> !m_tdata[hit_pkg::HIT_OUT_INL_BIT])
		else $error("zero denominator flagged as inlier");

	// a stalled result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NS-1] && !m_tready) |=> vld_q[NS-1])
		else $error("pending result dropped");

endmodule
